// File: rtl/core/ypf_pkg.sv
// ----------------------------------------------------------------------------
// ypf_pkg
// Shared types, register codes and helpers for the yaw PID controller.
// ----------------------------------------------------------------------------
package ypf_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT   = 3'd4;

	// Reset values
	localparam logic signed [31:0] PROP_GAIN_RST = 32'sd41943040; // 2.5 in Q8.24
	localparam logic [30:0]        OUT_LIMIT_RST = 31'd6553600;   // 100.0 in Q16.16

	// Position difference to velocity
	localparam logic signed [42:0] VEL_SCALE = 43'sd1000;

	// Gain products are Q16.16 * Q8.24; drop 24 fraction bits
	localparam int GAIN_FRAC = 24;

	localparam logic signed [42:0] S43_MAX = 43'sd2147483647;
	localparam logic signed [42:0] S43_MIN = -43'sd2147483648;

	// Microcode
	localparam int STEP_W = 4;

	typedef enum logic [2:0] {
		MUL_NONE        = 3'd0,
		MUL_VEL_SPEED   = 3'd1,
		MUL_BODY_TURN   = 3'd2,
		MUL_ERR_PROP    = 3'd3,
		MUL_SUM_INTEG   = 3'd4,
		MUL_GIMBAL_RATE = 3'd5
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD     = 2'd0,
		ACC_LD_TGT   = 2'd1,
		ACC_LD_PROD  = 2'd2,
		ACC_ADD_PROD = 2'd3
	} acc_op_t;

	typedef struct packed {
		mul_sel_t            mul_sel;
		acc_op_t             acc_op;
		logic                tgt_load;   // take new_target if requested
		logic                diff_wr;
		logic                vel_wr;
		logic                prev_wr;
		logic                tgt_sat_wr; // target <= sat(acc)
		logic                err_wr;
		logic                esum_wr;
		logic                out_wr;
		logic                jmp_noff;   // jump when feedforward is off
		logic [STEP_W-1:0]   jmp_to;
		logic                last;
	} cw_t;

	localparam cw_t CW_NOP = '{
		mul_sel: MUL_NONE,
		acc_op:  ACC_HOLD,
		jmp_to:  '0,
		default: 1'b0
	};

	// Saturate a signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
		logic signed [31:0] r;
		if (v > S43_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < S43_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/ypf_sequencer.sv
// ----------------------------------------------------------------------------
// ypf_sequencer
// Step counter and microcode ROM; while busy, issues one control word per cycle unless the result-write step stalls.
// ----------------------------------------------------------------------------
module ypf_sequencer
	import ypf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,    // transaction accepted this cycle
	input  logic ff_en,    // latched feedforward enable
	input  logic out_hold, // result register still occupied
	output logic busy,
	output cw_t  cw
);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	cw_t               word;
	logic              stall;
	logic              run;

	function automatic cw_t ucode(input logic [STEP_W-1:0] step);
		cw_t w;
		w = CW_NOP;
		unique case (step)
			4'd0: begin
				w.tgt_load = 1'b1;
				w.diff_wr  = 1'b1;
				w.jmp_noff = 1'b1;
				w.jmp_to   = 4'd6;
			end
			4'd1: begin
				w.vel_wr  = 1'b1;
				w.prev_wr = 1'b1;
			end
			4'd2: begin
				w.mul_sel = MUL_VEL_SPEED;
				w.acc_op  = ACC_LD_TGT;
			end
			4'd3: begin
				w.mul_sel = MUL_BODY_TURN;
				w.acc_op  = ACC_ADD_PROD;
			end
			4'd4: w.acc_op = ACC_ADD_PROD;
			4'd5: w.tgt_sat_wr = 1'b1;
			4'd6: w.err_wr = 1'b1;
			4'd7: begin
				w.mul_sel = MUL_ERR_PROP;
				w.esum_wr = 1'b1;
			end
			4'd8: begin
				w.mul_sel = MUL_SUM_INTEG;
				w.acc_op  = ACC_LD_PROD;
			end
			4'd9: begin
				w.mul_sel = MUL_GIMBAL_RATE;
				w.acc_op  = ACC_ADD_PROD;
			end
			4'd10: w.acc_op = ACC_ADD_PROD;
			4'd11: begin
				w.out_wr = 1'b1;
				w.last   = 1'b1;
			end
			default: w = CW_NOP;
		endcase
		return w;
	endfunction

	assign word  = ucode(step_q);
	assign stall = word.out_wr & out_hold;
	assign run   = busy_q & ~stall;
	assign cw    = run ? word : CW_NOP;
	assign busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (run) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else if (word.jmp_noff && !ff_en) begin
				step_q <= word.jmp_to;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/yaw_pid_with_feedforward.sv
// ----------------------------------------------------------------------------
// yaw_pid_with_feedforward
// Positional yaw PID with velocity and turn-rate feedforward, clamped output.
// ----------------------------------------------------------------------------
// Sequence: 12 microcode steps from input transaction to result valid with
//   feedforward on, 7 with it off; one step per cycle unless the final step
//   stalls on an undrained result register. A new item is taken only after the
//   last step; the single shared 32x32 multiplier and the step count set the pace.
// Reset: arst_n clears state (target, last position, error sum) to zero and
//   loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module yaw_pid_with_feedforward
	import ypf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,

	// input item channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 load_target,
	input  logic signed [31:0]   new_target,
	input  logic                 ff_enable,
	input  logic signed [31:0]   wheel_position,
	input  logic signed [31:0]   yaw_angle,
	input  logic signed [31:0]   body_rate,
	input  logic signed [31:0]   gimbal_rate,
	input  logic signed [31:0]   speed_ff_gain,
	input  logic signed [31:0]   turn_ff_gain,

	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 drive_positive,
	output logic [14:0]          drive_magnitude,
	output logic signed [31:0]   control_value
);

	// ---------------------------------------------------------------------
	// Configuration registers. Writes are always taken; unknown indexes are
	// dropped.
	// ---------------------------------------------------------------------
	logic signed [31:0] prop_gain_q;
	logic signed [31:0] integ_gain_q;
	logic signed [31:0] rate_gain_q;
	logic [30:0]        integ_limit_q;
	logic [30:0]        out_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= PROP_GAIN_RST;
			integ_gain_q  <= '0;
			rate_gain_q   <= '0;
			integ_limit_q <= '0;
			out_limit_q   <= OUT_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				REG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				REG_RATE_GAIN:   rate_gain_q   <= cfg_data;
				REG_INTEG_LIMIT: integ_limit_q <= cfg_data[30:0];
				REG_OUT_LIMIT:   out_limit_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// captured transaction payload
	logic               load_q;
	logic               ff_q;
	logic signed [31:0] new_tgt_q;
	logic signed [31:0] pos_q;
	logic signed [31:0] yaw_q;
	logic signed [31:0] body_q;
	logic signed [31:0] gimbal_q;
	logic signed [31:0] speed_gain_q;
	logic signed [31:0] turn_gain_q;

	// ---------------------------------------------------------------------
	// Sequencer. Takes a transaction only when no item is in flight; the
	// result register is separate, so the next item may start while the
	// previous result still waits downstream. The final step stalls if the
	// result register has not been drained.
	// ---------------------------------------------------------------------
	logic busy;
	logic in_acc;
	cw_t  cw;

	assign in_ready = ~busy;
	assign in_acc   = in_valid & in_ready;

	logic out_valid_q;

	ypf_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.ff_en    (ff_q),
		.out_hold (out_valid_q & ~out_ready),
		.busy     (busy),
		.cw       (cw)
	);

	// ---------------------------------------------------------------------
	// Input capture (payload, no reset)
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			load_q       <= load_target;
			ff_q         <= ff_enable;
			new_tgt_q    <= new_target;
			pos_q        <= wheel_position;
			yaw_q        <= yaw_angle;
			body_q       <= body_rate;
			gimbal_q     <= gimbal_rate;
			speed_gain_q <= speed_ff_gain;
			turn_gain_q  <= turn_ff_gain;
		end
	end

	// ---------------------------------------------------------------------
	// Datapath
	// ---------------------------------------------------------------------
	logic signed [31:0] tgt_q;   // target angle
	logic signed [31:0] prev_q;  // last wheel position
	logic signed [31:0] esum_q;  // clamped error sum
	logic signed [32:0] diff_q;
	logic signed [31:0] vel_q;
	logic signed [31:0] err_q;
	logic signed [63:0] prod_q;
	logic signed [41:0] acc_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [39:0] prod_sh;
	logic signed [41:0] prod_ext;
	logic signed [42:0] vel_wide;
	logic signed [32:0] err_wide;
	logic signed [32:0] esum_wide;
	logic signed [32:0] ilim;
	logic signed [32:0] esum_next;
	logic signed [41:0] olim;
	logic signed [41:0] ctrl_wide;
	logic signed [31:0] ctrl;
	logic [31:0]        ctrl_abs;

	// shared multiplier operand select
	always_comb begin
		unique case (cw.mul_sel)
			MUL_VEL_SPEED: begin
				mul_a = vel_q;
				mul_b = speed_gain_q;
			end
			MUL_BODY_TURN: begin
				mul_a = body_q;
				mul_b = turn_gain_q;
			end
			MUL_ERR_PROP: begin
				mul_a = err_q;
				mul_b = prop_gain_q;
			end
			MUL_SUM_INTEG: begin
				mul_a = esum_q;
				mul_b = integ_gain_q;
			end
			MUL_GIMBAL_RATE: begin
				mul_a = gimbal_q;
				mul_b = rate_gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// arithmetic shift of the exact product is floor rounding
	assign prod_sh  = prod_q[63:GAIN_FRAC];
	assign prod_ext = {{2{prod_sh[39]}}, prod_sh};

	assign vel_wide = {{10{diff_q[32]}}, diff_q} * VEL_SCALE;
	assign err_wide = {tgt_q[31], tgt_q} - {yaw_q[31], yaw_q};

	// error sum: add, then clamp to +-integ_limit
	assign esum_wide = {esum_q[31], esum_q} + {err_q[31], err_q};
	assign ilim      = {2'b00, integ_limit_q};
	always_comb begin
		priority if (esum_wide > ilim) begin
			esum_next = ilim;
		end else if (esum_wide < -ilim) begin
			esum_next = -ilim;
		end else begin
			esum_next = esum_wide;
		end
	end

	// output clamp to +-out_limit
	assign olim = {11'd0, out_limit_q};
	always_comb begin
		priority if (acc_q > olim) begin
			ctrl_wide = olim;
		end else if (acc_q < -olim) begin
			ctrl_wide = -olim;
		end else begin
			ctrl_wide = acc_q;
		end
	end
	assign ctrl     = ctrl_wide[31:0];
	assign ctrl_abs = ctrl[31] ? -ctrl : ctrl;

	always_ff @(posedge clk) begin
		if (cw.mul_sel != MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cw.acc_op)
			ACC_LD_TGT:   acc_q <= {{10{tgt_q[31]}}, tgt_q};
			ACC_LD_PROD:  acc_q <= prod_ext;
			ACC_ADD_PROD: acc_q <= acc_q + prod_ext;
			default: ;
		endcase
		if (cw.diff_wr) begin
			diff_q <= {pos_q[31], pos_q} - {prev_q[31], prev_q};
		end
		if (cw.vel_wr) begin
			vel_q <= sat32(vel_wide);
		end
		if (cw.err_wr) begin
			err_q <= sat32({{10{err_wide[32]}}, err_wide});
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q  <= '0;
			prev_q <= '0;
			esum_q <= '0;
		end else begin
			if (cw.tgt_load && load_q) begin
				tgt_q <= new_tgt_q;
			end else if (cw.tgt_sat_wr) begin
				tgt_q <= sat32({acc_q[41], acc_q});
			end
			if (cw.prev_wr) begin
				prev_q <= pos_q;
			end
			if (cw.esum_wr) begin
				esum_q <= esum_next[31:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	logic               pos_res_q;
	logic [14:0]        mag_res_q;
	logic signed [31:0] ctrl_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.out_wr) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_wr) begin
			pos_res_q  <= ~ctrl[31] & (|ctrl);
			mag_res_q  <= ctrl_abs[30:16];
			ctrl_res_q <= ctrl;
		end
	end

	assign out_valid       = out_valid_q;
	assign drive_positive  = pos_res_q;
	assign drive_magnitude = mag_res_q;
	assign control_value   = ctrl_res_q;

endmodule
